@@ rtl/kmt_pkg.sv @@
// Shared types and constants for the keypad matrix key list tracker.
`timescale 1ns / 1ps

package kmt_pkg;

  localparam int unsigned POS_W  = 8;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned CODE_W = 8;
  localparam int unsigned HOLD_W = 16;
  localparam int unsigned TIME_W = 32;

  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd500;
  localparam logic [POS_W-1:0]  POS_NONE   = 8'hFF;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_HOLD     = 2'd2,
    PH_RELEASED = 2'd3
  } phase_e;

  typedef struct packed {
    logic              scan_start;
    logic [2:0]        row;
    logic [3:0]        col;
    logic              key_closed;
    logic [CODE_W-1:0] key_code;
    logic [TIME_W-1:0] now_ms;
  } kmt_in_word_t;

  typedef struct packed {
    logic              state_changed;
    logic [SLOT_W-1:0] slot;
    logic [CODE_W-1:0] changed_code;
    logic [1:0]        new_state;
    logic              scan_activity;
  } kmt_out_word_t;

  typedef struct packed {
    logic load;
    logic search;
    logic commit;
  } kmt_cmd_t;

  typedef struct packed {
    logic skip;
    logic last;
  } kmt_status_t;

endpackage

@@ rtl/kmt_ctrl.sv @@
// Controller state machine: load, slot search sweep and commit.
`timescale 1ns / 1ps

module kmt_ctrl import kmt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        out_free_i,
  input  kmt_status_t status_i,
  output logic        in_stall_o,
  output kmt_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_COMMIT = 3'b100
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status_i.skip) begin
          state_d = ST_COMMIT;
        end else begin
          cmd_o.search = 1'b1;
          if (status_i.last) begin
            state_d = ST_COMMIT;
          end
        end
      end
      ST_COMMIT: begin
        if (out_free_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_commit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> out_free_i)
    else $error("commit issued while output register is occupied");

  a_load_starts_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_SEARCH))
    else $error("load not followed by slot search");

endmodule

@@ rtl/kmt_dpath.sv @@
// Datapath: slot list, position search, phase update and hold timer.
`timescale 1ns / 1ps

module kmt_dpath import kmt_pkg::*; #(
  parameter int unsigned LIST_SLOTS = 10,
  parameter int unsigned MAX_ROWS   = 8,
  parameter int unsigned MAX_COLS   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kmt_cmd_t          cmd_i,
  input  kmt_in_word_t      in_word_i,
  input  logic [HOLD_W-1:0] hold_time_i,
  output kmt_status_t       status_o,
  output kmt_out_word_t     result_o
);

  localparam int unsigned IDX_W = (LIST_SLOTS > 1) ? $clog2(LIST_SLOTS) : 1;

  logic [CODE_W-1:0] code_q  [LIST_SLOTS];
  logic [POS_W-1:0]  pos_q   [LIST_SLOTS];
  phase_e            phase_q [LIST_SLOTS];
  logic              flag_q  [LIST_SLOTS];
  logic [TIME_W-1:0] hold_start_q;
  logic              activity_q;

  kmt_in_word_t      item_q;
  logic [IDX_W-1:0]  idx_q;
  logic              found_q, free_q;
  logic [IDX_W-1:0]  found_idx_q, free_idx_q;
  phase_e            found_phase_q;
  logic [CODE_W-1:0] found_code_q;

  logic              skip;
  logic [POS_W-1:0]  item_pos;
  logic [IDX_W-1:0]  sel_idx;
  phase_e            cur_phase, nx_phase;
  logic [TIME_W-1:0] elapsed;
  logic              apply, changed;
  logic [CODE_W-1:0] sel_code;

  assign skip = (item_q.key_code == '0) ||
                ({1'b0, item_q.row} >= 4'(MAX_ROWS)) ||
                ({1'b0, item_q.col} >= 5'(MAX_COLS));
  assign item_pos = POS_W'(int'(item_q.row) * MAX_COLS + int'(item_q.col));

  assign status_o.skip = skip;
  assign status_o.last = (idx_q == IDX_W'(LIST_SLOTS - 1));

  assign sel_idx   = found_q ? found_idx_q : free_idx_q;
  assign cur_phase = found_q ? found_phase_q : PH_IDLE;
  assign sel_code  = found_q ? found_code_q : item_q.key_code;
  assign elapsed   = item_q.now_ms - hold_start_q;

  always_comb begin
    nx_phase = cur_phase;
    case (cur_phase)
      PH_IDLE: begin
        if (item_q.key_closed) nx_phase = PH_PRESSED;
      end
      PH_PRESSED: begin
        if (elapsed > TIME_W'(hold_time_i)) begin
          nx_phase = PH_HOLD;
        end else if (!item_q.key_closed) begin
          nx_phase = PH_RELEASED;
        end
      end
      PH_HOLD: begin
        if (!item_q.key_closed) nx_phase = PH_RELEASED;
      end
      PH_RELEASED: begin
        nx_phase = PH_IDLE;
      end
      default: begin
        nx_phase = cur_phase;
      end
    endcase
  end

  assign apply   = !skip && (found_q || (item_q.key_closed && free_q));
  assign changed = apply && (nx_phase != cur_phase);

  always_comb begin
    result_o               = '0;
    result_o.scan_activity = activity_q | changed;
    if (changed) begin
      result_o.state_changed = 1'b1;
      result_o.slot          = SLOT_W'(sel_idx);
      result_o.changed_code  = sel_code;
      result_o.new_state     = nx_phase;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_word_i;
    end
    if (cmd_i.search) begin
      if (!found_q && pos_q[idx_q] == item_pos) begin
        found_idx_q   <= idx_q;
        found_phase_q <= phase_q[idx_q];
        found_code_q  <= code_q[idx_q];
      end
      if (!free_q && code_q[idx_q] == '0) begin
        free_idx_q <= idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      found_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (cmd_i.load) begin
      idx_q   <= '0;
      found_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (cmd_i.search) begin
      idx_q <= idx_q + 1'b1;
      if (pos_q[idx_q] == item_pos) found_q <= 1'b1;
      if (code_q[idx_q] == '0) free_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LIST_SLOTS; i++) begin
        code_q[i]  <= '0;
        pos_q[i]   <= POS_NONE;
        phase_q[i] <= PH_IDLE;
        flag_q[i]  <= 1'b0;
      end
      hold_start_q <= '0;
      activity_q   <= 1'b0;
    end else begin
      if (cmd_i.load && in_word_i.scan_start) begin
        for (int i = 0; i < LIST_SLOTS; i++) begin
          if (phase_q[i] == PH_IDLE) begin
            code_q[i] <= '0;
            pos_q[i]  <= POS_NONE;
            flag_q[i] <= 1'b0;
          end
        end
        activity_q <= 1'b0;
      end
      if (cmd_i.commit && apply) begin
        for (int i = 0; i < LIST_SLOTS; i++) begin
          if (IDX_W'(i) == sel_idx) begin
            phase_q[i] <= nx_phase;
            flag_q[i]  <= changed;
            if (!found_q) begin
              code_q[i] <= item_q.key_code;
              pos_q[i]  <= item_pos;
            end
          end
        end
        if (changed && nx_phase == PH_PRESSED) begin
          hold_start_q <= item_q.now_ms;
        end
      end
      if (cmd_i.commit && changed) begin
        activity_q <= 1'b1;
      end
    end
  end

  a_change_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && changed) |-> (found_q || free_q))
    else $error("slot change without a matched or free slot");

endmodule

@@ rtl/keypad_matrix_key_list_tracker.sv @@
// Top level of the keypad matrix key list tracker with hold detection.
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i) takes one scanned key
//   position per word; scan_start marks the first position of a scan.
//   Output channel (out_valid_o / out_stall_i / out_word_o) returns exactly one
//   result word per input word, in order. The user must write hold_time through
//   cfg_we_i / cfg_wdata_i only while the block is idle (not enforced here).
// Timing:
//   An accepted word is searched against the slot list one slot per cycle and
//   is then committed once the output register is free; an ignored position
//   skips the search. One word is in work at a time; the next is accepted as
//   soon as the previous is committed.
// Reset:
//   All slots are empty and idle, the hold timer and scan activity are cleared,
//   and hold_time returns to 500 ms.
// Stall:
//   A finished result waits in the output register; the next word is still
//   accepted and searched, and its commit waits until the register frees up.
`timescale 1ns / 1ps

module keypad_matrix_key_list_tracker import kmt_pkg::*; #(
  parameter int unsigned LIST_SLOTS = 10,
  parameter int unsigned MAX_ROWS   = 8,
  parameter int unsigned MAX_COLS   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  kmt_in_word_t      in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output kmt_out_word_t     out_word_o,
  input  logic              cfg_we_i,
  input  logic [HOLD_W-1:0] cfg_wdata_i
);

  logic [HOLD_W-1:0] hold_time_q;
  logic              out_valid_q;
  kmt_out_word_t     out_word_q;
  logic              out_free;
  kmt_cmd_t          cmd;
  kmt_status_t       status;
  kmt_out_word_t     result;

  assign out_free = !out_valid_q || !out_stall_i;

  kmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  kmt_dpath #(
    .LIST_SLOTS (LIST_SLOTS),
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_word_i   (in_word_i),
    .hold_time_i (hold_time_q),
    .status_o    (status),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_time_q <= HOLD_RESET;
    end else if (cfg_we_i) begin
      hold_time_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.commit) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_commit_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_valid_o)
    else $error("committed result not presented");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted again before the word was processed");

endmodule

@@ tb/sv/keypad_matrix_key_list_tracker_tb.sv @@
// Self-checking testbench for the keypad matrix key list tracker.
`timescale 1ns / 1ps

module keypad_matrix_key_list_tracker_tb import kmt_pkg::*; ();

  localparam int N_SLOTS     = 10;
  localparam int N_ROWS      = 8;
  localparam int N_COLS      = 16;
  localparam int SETTLE      = 32;
  localparam int LONG_STALL  = 300;
  localparam int PHASE_WORDS = 125;
  localparam int N_KEYS      = 12;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  kmt_in_word_t      in_word_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  kmt_out_word_t     out_word_o;
  logic              cfg_we_i    = 1'b0;
  logic [HOLD_W-1:0] cfg_wdata_i = '0;

  keypad_matrix_key_list_tracker uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // tracker state as predicted
  logic [CODE_W-1:0] tk_code [N_SLOTS];
  logic [POS_W-1:0]  tk_pos  [N_SLOTS];
  phase_e            tk_phase[N_SLOTS];
  logic              tk_flag [N_SLOTS];
  logic [TIME_W-1:0] tk_hold_t0;
  logic              tk_activity;
  logic [HOLD_W-1:0] tk_hold_time;

  kmt_in_word_t  pending_words[$];
  kmt_out_word_t expected_results[$];

  int send_idle_pct   = 8;
  int recv_idle_pct   = 76;
  int long_hold_asked = 0;
  int long_hold_taken = 0;
  int stall_left      = 0;
  int errors          = 0;
  int words_accepted  = 0;
  int results_checked = 0;
  int state_changes   = 0;
  int hold_entries    = 0;
  int cfg_writes      = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAIL keypad_matrix_key_list_tracker");
    $finish;
  end

  function automatic bit advance_key(int s, logic closed, logic [TIME_W-1:0] now);
    phase_e            cur;
    phase_e            nxt;
    logic [TIME_W-1:0] elapsed;
    cur        = tk_phase[s];
    nxt        = cur;
    elapsed    = now - tk_hold_t0;
    tk_flag[s] = 1'b0;
    case (cur)
      PH_IDLE: begin
        if (closed) begin
          nxt        = PH_PRESSED;
          tk_hold_t0 = now;
        end
      end
      PH_PRESSED: begin
        if (elapsed > {16'd0, tk_hold_time}) nxt = PH_HOLD;
        else if (!closed) nxt = PH_RELEASED;
      end
      PH_HOLD: begin
        if (!closed) nxt = PH_RELEASED;
      end
      default: nxt = PH_IDLE;
    endcase
    if (nxt == cur) return 1'b0;
    tk_phase[s] = nxt;
    tk_flag[s]  = 1'b1;
    return 1'b1;
  endfunction

  function automatic kmt_out_word_t track_key_word(kmt_in_word_t w);
    kmt_out_word_t    r;
    logic [POS_W-1:0] pos;
    int               hit;
    bit               moved;
    r     = '0;
    hit   = -1;
    moved = 1'b0;
    if (w.scan_start) begin
      for (int i = 0; i < N_SLOTS; i++) begin
        if (tk_phase[i] == PH_IDLE) begin
          tk_code[i] = '0;
          tk_pos[i]  = POS_NONE;
          tk_flag[i] = 1'b0;
        end
      end
      tk_activity = 1'b0;
    end
    if (w.key_code != 0 && int'(w.row) < N_ROWS && int'(w.col) < N_COLS) begin
      pos = POS_W'(int'(w.row) * N_COLS + int'(w.col));
      for (int i = 0; i < N_SLOTS; i++) begin
        if (hit < 0 && tk_pos[i] == pos) hit = i;
      end
      if (hit >= 0) begin
        moved = advance_key(hit, w.key_closed, w.now_ms);
      end else if (w.key_closed) begin
        for (int i = 0; i < N_SLOTS; i++) begin
          if (hit < 0 && tk_code[i] == 0) hit = i;
        end
        if (hit >= 0) begin
          tk_code[hit]  = w.key_code;
          tk_pos[hit]   = pos;
          tk_phase[hit] = PH_IDLE;
          moved = advance_key(hit, w.key_closed, w.now_ms);
        end
      end
    end
    if (moved) begin
      tk_activity     = 1'b1;
      r.state_changed = 1'b1;
      r.slot          = SLOT_W'(hit);
      r.changed_code  = tk_code[hit];
      r.new_state     = tk_phase[hit];
    end
    r.scan_activity = tk_activity;
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    logic         nv;
    kmt_in_word_t nw;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      nv = in_valid_i;
      nw = in_word_i;
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(track_key_word(in_word_i));
        words_accepted++;
        nv = 1'b0;
      end
      if (!nv && pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nw = pending_words.pop_front();
        nv = 1'b1;
      end
      in_valid_i <= nv;
      in_word_i  <= nw;
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk_i) begin
    kmt_out_word_t want;
    logic          ns;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result word arrived with none expected");
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("state_changed", 32'(want.state_changed),
                      32'(out_word_o.state_changed));
          check_field("slot", 32'(want.slot), 32'(out_word_o.slot));
          check_field("changed_code", 32'(want.changed_code),
                      32'(out_word_o.changed_code));
          check_field("new_state", 32'(want.new_state), 32'(out_word_o.new_state));
          check_field("scan_activity", 32'(want.scan_activity),
                      32'(out_word_o.scan_activity));
          results_checked++;
          if (want.state_changed) state_changes++;
          if (want.state_changed && want.new_state == PH_HOLD) hold_entries++;
        end
      end
      if (long_hold_taken != long_hold_asked) begin
        long_hold_taken = long_hold_asked;
        stall_left      = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        ns = 1'b1;
      end else begin
        ns = ($urandom_range(99) < recv_idle_pct);
      end
      out_stall_i <= ns;
    end
  end

  task automatic queue_key(bit ss, logic [2:0] r, logic [3:0] c, bit cl,
                           logic [CODE_W-1:0] code, logic [TIME_W-1:0] t);
    kmt_in_word_t w;
    w.scan_start = ss;
    w.row        = r;
    w.col        = c;
    w.key_closed = cl;
    w.key_code   = code;
    w.now_ms     = t;
    pending_words.push_back(w);
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_words.size() != 0 || in_valid_i || expected_results.size() != 0);
  endtask

  task automatic write_hold(logic [HOLD_W-1:0] v);
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    tk_hold_time = v;
    cfg_writes++;
  endtask

  task automatic run_phase(logic [HOLD_W-1:0] hold, int s_pct, int r_pct, bit squeeze);
    logic [2:0]        krow [N_KEYS];
    logic [3:0]        kcol [N_KEYS];
    logic [CODE_W-1:0] kcode[N_KEYS];
    bit                down [N_KEYS];
    logic [TIME_W-1:0] t;
    int                sent;
    int                npos;
    int                step_max;
    bit                paused;
    bit                squeezed;
    write_hold(hold);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int k = 0; k < N_KEYS; k++) begin
      krow[k]  = 3'($urandom);
      kcol[k]  = 4'($urandom);
      kcode[k] = ($urandom_range(7) == 0) ? 8'd0 : CODE_W'($urandom_range(255, 1));
      down[k]  = 1'b0;
    end
    t        = $urandom;
    npos     = $urandom_range(N_KEYS, 3);
    step_max = int'(hold) / 3 + 8;
    sent     = 0;
    paused   = 1'b0;
    squeezed = 1'b0;
    while (sent < PHASE_WORDS) begin
      if ($urandom_range(9) == 0) begin
        queue_key(1'($urandom_range(1)), 3'($urandom), 4'($urandom),
                  1'($urandom_range(1)), CODE_W'($urandom), $urandom);
        sent++;
      end else begin
        t += ($urandom_range(19) == 0) ? $urandom : $urandom_range(step_max);
        for (int k = 0; k < npos; k++) begin
          if ($urandom_range(99) < 20) down[k] = !down[k];
          queue_key(k == 0, krow[k], kcol[k], down[k], kcode[k], t);
          sent++;
        end
      end
      if (squeeze && !squeezed && sent >= 40) begin
        long_hold_asked++;
        squeezed = 1'b1;
      end
      if (!paused && sent >= PHASE_WORDS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    tk_hold_time = HOLD_RESET;
    tk_hold_t0   = '0;
    tk_activity  = 1'b0;
    for (int i = 0; i < N_SLOTS; i++) begin
      tk_code[i]  = '0;
      tk_pos[i]   = POS_NONE;
      tk_phase[i] = PH_IDLE;
      tk_flag[i]  = 1'b0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_key(1'b1, 3'd0, 4'd0, 1'b1, 8'd0, 32'd0);
    queue_key(1'b0, 3'd0, 4'd0, 1'b1, 8'hFF, 32'd0);
    queue_key(1'b0, 3'd0, 4'd0, 1'b1, 8'hFF, 32'd500);
    queue_key(1'b0, 3'd0, 4'd0, 1'b1, 8'hFF, 32'd501);
    queue_key(1'b0, 3'd0, 4'd0, 1'b1, 8'hFF, 32'd600);
    queue_key(1'b0, 3'd0, 4'd0, 1'b0, 8'hFF, 32'd700);
    queue_key(1'b0, 3'd0, 4'd0, 1'b0, 8'hFF, 32'd800);
    queue_key(1'b0, 3'd1, 4'd1, 1'b0, 8'd5, 32'd800);
    queue_key(1'b1, 3'd7, 4'd15, 1'b1, 8'd1, 32'hFFFF_FFFF);
    queue_key(1'b0, 3'd7, 4'd15, 1'b1, 8'd1, 32'd500);
    for (int k = 0; k < 9; k++) begin
      queue_key(1'b0, 3'd2, 4'(k), 1'b1, 8'(10 + k), 32'd1000);
    end
    queue_key(1'b0, 3'd3, 4'd3, 1'b1, 8'd77, 32'd1000);
    queue_key(1'b0, 3'd2, 4'd0, 1'b0, 8'd10, 32'd1001);
    queue_key(1'b0, 3'd2, 4'd0, 1'b1, 8'd10, 32'd1002);
    queue_key(1'b1, 3'd6, 4'd9, 1'b1, 8'd200, 32'd1003);
    queue_key(1'b0, 3'd2, 4'd1, 1'b0, 8'd11, 32'd1003);

    run_phase(16'd0, 8, 76, 1'b0);
    run_phase(16'hFFFF, 8, 76, 1'b1);
    run_phase(HOLD_W'($urandom), 76, 8, 1'b0);
    run_phase(16'd1, 76, 8, 1'b0);
    run_phase(HOLD_RESET, 0, 0, 1'b1);
    run_phase(HOLD_W'($urandom_range(2000)), 0, 0, 1'b0);

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    $display("Covered %0d words, %0d results checked, %0d register writes.",
             words_accepted, results_checked, cfg_writes);
    $display("Saw %0d slot state changes, %0d of them into hold.", state_changes, hold_entries);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS keypad_matrix_key_list_tracker");
    end else begin
      $display("FAIL keypad_matrix_key_list_tracker");
    end
    $finish;
  end

endmodule
